### rtl/lor_pkg.sv
package lor_pkg;

  localparam int CFG_W        = 11;
  localparam int CFG_AW       = 3;
  localparam int DATA_W       = 32;
  localparam int AREA_W       = 21;
  localparam int MAX_COLS_DEF = 1024;
  localparam int MAX_ROWS_DEF = 1024;

  localparam logic [AREA_W-1:0] AREA_MAX  = '1;
  localparam logic [CFG_W-1:0]  CFG_RESET = 11'd1024;

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

endpackage

### rtl/largest_ones_rectangle.sv
// Largest all-black rectangle of a binary image.
// Input channel: one cell per item (cell_black_i), row-major order, handshake
// in_valid_i / in_stall_o. Output channel: max_area_o with out_valid_o /
// out_stall_i, one item after the last cell of each rows-by-columns matrix.
// Configuration: APB registers rows_in_use (0x0) and cols_in_use (0x4).
// Flow: a cell first pops every stack entry taller than its column height,
// then is pushed; input stalls while it pops. The next cell is taken in the
// push cycle, but for a row's last cell. The loop is the stack memory read,
// with the entry below the top prefetched. At the end of a row the stack
// drains, one pop per cycle; once it is empty the state returns to idle,
// where the next row's first cell is taken. After the last row's drain the
// last product passes the product and best-area registers, and the finish
// state then loads the area into the output register once it is free.
// Column heights sit in a RAM covered by a fill count, so reset takes
// effect at once with no clearing pass; each matrix end restarts the count.
// A stalled output holds its item; cells are still taken until the next
// matrix ends; its result then waits for the output register, input stalled.
module largest_ones_rectangle #(
  parameter int MAX_COLS = lor_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = lor_pkg::MAX_ROWS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            cell_black_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [lor_pkg::AREA_W-1:0]      max_area_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lor_pkg::CFG_AW-1:0]      paddr,
  input  logic [lor_pkg::DATA_W-1:0]      pwdata,
  output logic [lor_pkg::DATA_W-1:0]      prdata,
  output logic                            pready
);

  localparam int CW  = $clog2(MAX_COLS);
  localparam int RPW = $clog2(MAX_ROWS);
  localparam int DW  = CW + 1;
  localparam int HW  = RPW + 1;
  localparam int EW  = CW + HW;
  localparam int PW  = HW + DW;
  localparam int SW  = (PW > lor_pkg::AREA_W) ? PW : lor_pkg::AREA_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_POP   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [HW-1:0] rows_eff;
  logic [DW-1:0] cols_eff;

  lor_cfg #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .rows_o (rows_eff),
    .cols_o (cols_eff)
  );

  logic [HW-1:0] colh_mem [MAX_COLS];
  logic [EW-1:0] stk_mem  [MAX_COLS];

  logic [1:0]    state_q, state_d;
  logic          first_q, first_d;
  logic          black_q, black_d;
  logic [CW-1:0] cur_col_q, cur_col_d;
  logic [HW-1:0] hcur_q, hcur_d;
  logic [CW-1:0] col_q, col_d;
  logic [RPW-1:0] row_q, row_d;
  logic [DW-1:0] fill_q, fill_d;
  logic [DW-1:0] depth_q, depth_d;
  logic [CW-1:0] top_col_q, top_col_d, below_col_q, below_col_d;
  logic [HW-1:0] top_h_q, top_h_d, below_h_q, below_h_d;
  logic [EW-1:0] stk_rd_q;
  logic [HW-1:0] colh_rd_q;
  logic [PW-1:0] prod_q, prod_d;
  logic          prod_v_q, prod_v_d;
  logic [lor_pkg::AREA_W-1:0] best_q, best_d, best_next, prod_sat;
  logic          out_valid_q, out_valid_d;
  logic [lor_pkg::AREA_W-1:0] out_data_q, out_data_d;

  logic [HW-1:0] h_prev, h_new, h_cur;
  logic          pop_now, row_end, in_acc, colh_we, stk_we;
  logic [DW-1:0] edge_pos, width, depth_m1;
  logic [SW-1:0] prod_ext;
  logic [CW-1:0] stk_ra;

  assign h_prev = (DW'(cur_col_q) < fill_q) ? colh_rd_q : '0;
  assign h_new  = !black_q ? '0 :
                  (h_prev >= HW'(MAX_ROWS)) ? HW'(MAX_ROWS) : h_prev + HW'(1);
  assign h_cur  = first_q ? h_new : hcur_q;

  assign row_end  = !((DW'(cur_col_q) + DW'(1)) < cols_eff);
  assign pop_now  = (depth_q != '0) &&
                    ((state_q == S_DRAIN) || ((state_q == S_POP) && (top_h_q > h_cur)));
  assign edge_pos = (state_q == S_DRAIN) ? DW'(cur_col_q) + DW'(1) : DW'(cur_col_q);
  assign depth_m1 = depth_q - DW'(1);
  assign width    = (depth_m1 == '0) ? edge_pos : edge_pos - DW'(below_col_q) - DW'(1);

  assign in_stall_o = !((state_q == S_IDLE) ||
                        ((state_q == S_POP) && !pop_now && !row_end));
  assign in_acc     = in_valid_i && !in_stall_o;

  assign colh_we = (state_q == S_POP) && first_q;
  assign stk_we  = (state_q == S_POP) && !pop_now && (depth_q < DW'(MAX_COLS));

  assign prod_ext  = SW'(prod_q);
  assign prod_sat  = (prod_ext > SW'(lor_pkg::AREA_MAX)) ? lor_pkg::AREA_MAX :
                     prod_ext[lor_pkg::AREA_W-1:0];
  assign best_next = (prod_v_q && (prod_sat > best_q)) ? prod_sat : best_q;

  always_comb begin
    state_d     = state_q;
    first_d     = 1'b0;
    black_d     = black_q;
    cur_col_d   = cur_col_q;
    hcur_d      = h_cur;
    col_d       = col_q;
    row_d       = row_q;
    fill_d      = fill_q;
    depth_d     = depth_q;
    top_col_d   = top_col_q;
    top_h_d     = top_h_q;
    below_col_d = below_col_q;
    below_h_d   = below_h_q;
    prod_v_d    = pop_now;
    prod_d      = PW'(top_h_q) * PW'(width);
    best_d      = best_next;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;

    if (colh_we && (DW'(cur_col_q) == fill_q)) begin
      fill_d = fill_q + DW'(1);
    end

    if (pop_now) begin
      depth_d     = depth_m1;
      top_col_d   = below_col_q;
      top_h_d     = below_h_q;
      below_col_d = stk_rd_q[EW-1:HW];
      below_h_d   = stk_rd_q[HW-1:0];
    end

    unique case (state_q)
      S_IDLE: ;
      S_POP: begin
        if (!pop_now) begin
          if (stk_we) begin
            depth_d     = depth_q + DW'(1);
            top_col_d   = cur_col_q;
            top_h_d     = h_cur;
            below_col_d = top_col_q;
            below_h_d   = top_h_q;
          end
          if (row_end) begin
            col_d   = '0;
            state_d = S_DRAIN;
          end else begin
            col_d   = cur_col_q + CW'(1);
            state_d = S_IDLE;
          end
        end
      end
      S_DRAIN: begin
        if (depth_q == '0) begin
          if ((HW'(row_q) + HW'(1)) < rows_eff) begin
            row_d   = row_q + RPW'(1);
            state_d = S_IDLE;
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_data_d  = best_next;
          best_d      = '0;
          row_d       = '0;
          col_d       = '0;
          fill_d      = '0;
          depth_d     = '0;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (in_acc) begin
      state_d   = S_POP;
      first_d   = 1'b1;
      black_d   = cell_black_i;
      cur_col_d = col_d;
    end
  end

  // entry below the next below-top entry, ready for a pop in the next cycle
  assign stk_ra = CW'(depth_d - DW'(3));

  always_ff @(posedge clk_i) begin
    if (colh_we) begin
      colh_mem[cur_col_q] <= h_new;
    end
    colh_rd_q <= colh_mem[col_d];
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[depth_q[CW-1:0]] <= {cur_col_q, h_cur};
    end
    stk_rd_q <= stk_mem[stk_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      first_q     <= 1'b0;
      col_q       <= '0;
      row_q       <= '0;
      fill_q      <= '0;
      depth_q     <= '0;
      prod_v_q    <= 1'b0;
      best_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      first_q     <= first_d;
      col_q       <= col_d;
      row_q       <= row_d;
      fill_q      <= fill_d;
      depth_q     <= depth_d;
      prod_v_q    <= prod_v_d;
      best_q      <= best_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    black_q     <= black_d;
    cur_col_q   <= cur_col_d;
    hcur_q      <= hcur_d;
    top_col_q   <= top_col_d;
    top_h_q     <= top_h_d;
    below_col_q <= below_col_d;
    below_h_q   <= below_h_d;
    prod_q      <= prod_d;
    out_data_q  <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign max_area_o  = out_data_q;

endmodule

### rtl/lor_cfg.sv
module lor_cfg #(
  parameter int MAX_ROWS = lor_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = lor_pkg::MAX_COLS_DEF,
  localparam int RW = $clog2(MAX_ROWS) + 1,
  localparam int DW = $clog2(MAX_COLS) + 1
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lor_pkg::CFG_AW-1:0]      paddr,
  input  logic [lor_pkg::DATA_W-1:0]      pwdata,
  output logic [lor_pkg::DATA_W-1:0]      prdata,
  output logic                            pready,
  output logic [RW-1:0]                   rows_o,
  output logic [DW-1:0]                   cols_o
);

  localparam int RGW = (lor_pkg::CFG_W > RW) ? lor_pkg::CFG_W : RW;
  localparam int CGW = (lor_pkg::CFG_W > DW) ? lor_pkg::CFG_W : DW;

  logic [lor_pkg::CFG_W-1:0] rows_q, cols_q;
  logic                      wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= lor_pkg::CFG_RESET;
      cols_q <= lor_pkg::CFG_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        lor_pkg::REG_ROWS: rows_q <= pwdata[lor_pkg::CFG_W-1:0];
        lor_pkg::REG_COLS: cols_q <= pwdata[lor_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      lor_pkg::REG_ROWS: prdata = lor_pkg::DATA_W'(rows_q);
      lor_pkg::REG_COLS: prdata = lor_pkg::DATA_W'(cols_q);
      default:           prdata = '0;
    endcase
  end

  // zero counts as one, above the maximum counts as the maximum
  always_comb begin
    if (rows_q == '0) begin
      rows_o = RW'(1);
    end else if (RGW'(rows_q) > RGW'(MAX_ROWS)) begin
      rows_o = RW'(MAX_ROWS);
    end else begin
      rows_o = RW'(rows_q);
    end
    if (cols_q == '0) begin
      cols_o = DW'(1);
    end else if (CGW'(cols_q) > CGW'(MAX_COLS)) begin
      cols_o = DW'(MAX_COLS);
    end else begin
      cols_o = DW'(cols_q);
    end
  end

endmodule
